[src/mall_pkg.sv]
package mall_pkg;

    localparam int WINDOW_DEFAULT = 10;

    localparam int SAMPLE_W    = 10;
    localparam int AVG_W       = 14;
    localparam int TENTHS_W    = 10;
    localparam int USED_W      = 4;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 72;

    localparam int FULL_SCALE  = 1023;
    localparam int TENTHS_SPAN = 1000;

    // x*1000 for x up to full scale
    localparam int TENTHS_N_W  = 20;
    localparam int LOW_BITS    = 10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCALE,
        ST_DIVIDE,
        ST_FINISH
    } mall_state_t;

    typedef struct packed {
        logic accept;
        logic update;
        logic scale;
        logic step;
        logic finish;
    } mall_cmd_t;

    typedef struct packed {
        logic div_last;
    } mall_status_t;

    // floor(n/1023) for n <= 1023000: n = 1024a + b, so n = 1023a + (a + b)
    // and a + b stays below twice the divisor.
    function automatic logic [TENTHS_W-1:0] tenths_of(input logic [TENTHS_N_W-1:0] n);
        logic [TENTHS_W:0]   a;
        logic [TENTHS_W+1:0] r;
        logic [TENTHS_W:0]   q;
        a = {1'b0, n[TENTHS_N_W-1:LOW_BITS]};
        r = {1'b0, a} + {2'b0, n[LOW_BITS-1:0]};
        q = a + ((r >= (TENTHS_W+2)'(FULL_SCALE)) ? (TENTHS_W+1)'(1) : (TENTHS_W+1)'(0));
        if (q > (TENTHS_W+1)'(TENTHS_SPAN))
        begin
            q = (TENTHS_W+1)'(TENTHS_SPAN);
        end
        return q[TENTHS_W-1:0];
    endfunction

endpackage

[src/mall_ram.sv]
module mall_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 10,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/mall_ctrl.sv]
module mall_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  mall_pkg::mall_status_t status,
    output mall_pkg::mall_cmd_t    cmd
);

    import mall_pkg::*;

    mall_state_t state_reg;
    mall_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_UPDATE: cmd.update = 1'b1;
            ST_SCALE:  cmd.scale  = 1'b1;
            ST_DIVIDE: cmd.step   = 1'b1;
            ST_FINISH: cmd.finish = out_free;
            default:   cmd = '0;
        endcase
    end

    // a new result wins over the handshake that frees the register
    always_comb
    begin
        priority if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

[src/mall_datapath.sv]
module mall_datapath #(
    parameter int WINDOW = mall_pkg::WINDOW_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [mall_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic [mall_pkg::M_TDATA_W-1:0]    m_tdata,
    input  mall_pkg::mall_cmd_t                cmd,
    output mall_pkg::mall_status_t             status
);

    import mall_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(WINDOW * FULL_SCALE + 1);
    localparam int DIV_W  = $clog2(WINDOW * FULL_SCALE * TENTHS_SPAN + 1);
    localparam int STEP_W = $clog2(DIV_W);

    logic [SAMPLE_W-1:0] sample_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;
    logic                full;
    logic [SAMPLE_W-1:0] ring_rdata;
    logic [SAMPLE_W-1:0] oldest;

    logic [DIV_W-1:0]    q4_dvd_reg;
    logic [DIV_W-1:0]    q4_dvd_next;
    logic [CNT_W-1:0]    q4_rem_reg;
    logic [CNT_W-1:0]    q4_rem_next;
    logic [DIV_W-1:0]    dk_dvd_reg;
    logic [DIV_W-1:0]    dk_dvd_next;
    logic [CNT_W-1:0]    dk_rem_reg;
    logic [CNT_W-1:0]    dk_rem_next;
    logic [STEP_W-1:0]   step_reg;

    logic [CNT_W:0]      q4_sh;
    logic [CNT_W:0]      q4_sub;
    logic [CNT_W:0]      dk_sh;
    logic [CNT_W:0]      dk_sub;
    logic [CNT_W:0]      divisor;

    logic [TENTHS_W-1:0] raw_dark_reg;
    logic [TENTHS_N_W-1:0] raw_scaled;
    logic [CNT_W+USED_W-1:0] used_ext;

    logic [SAMPLE_W-1:0] raw_echo_reg;
    logic [AVG_W-1:0]    average_q4_reg;
    logic [TENTHS_W-1:0] raw_dark_tenths_reg;
    logic [TENTHS_W-1:0] raw_bright_tenths_reg;
    logic [TENTHS_W-1:0] avg_dark_tenths_reg;
    logic [TENTHS_W-1:0] avg_bright_tenths_reg;
    logic [USED_W-1:0]   samples_used_reg;
    logic [TENTHS_W-1:0] avg_dark;

    mall_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (cmd.update),
        .wr_addr (slot_reg),
        .wr_data (sample_reg),
        .rd_addr (slot_reg),
        .rd_data (ring_rdata)
    );

    // slots past the fill count were never written and count as zero
    assign full      = (fill_reg == CNT_W'(WINDOW));
    assign oldest    = full ? ring_rdata : '0;
    assign sum_next  = sum_reg - SUM_W'(oldest) + SUM_W'(sample_reg);
    assign slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + SLOT_W'(1);
    assign fill_next = full ? fill_reg : fill_reg + CNT_W'(1);

    // two restoring division lanes by the fill count, one quotient bit a step
    assign divisor = {1'b0, fill_reg};
    assign q4_sh   = {q4_rem_reg, q4_dvd_reg[DIV_W-1]};
    assign q4_sub  = q4_sh - divisor;
    assign dk_sh   = {dk_rem_reg, dk_dvd_reg[DIV_W-1]};
    assign dk_sub  = dk_sh - divisor;

    always_comb
    begin
        if (q4_sh >= divisor)
        begin
            q4_rem_next = q4_sub[CNT_W-1:0];
            q4_dvd_next = {q4_dvd_reg[DIV_W-2:0], 1'b1};
        end
        else
        begin
            q4_rem_next = q4_sh[CNT_W-1:0];
            q4_dvd_next = {q4_dvd_reg[DIV_W-2:0], 1'b0};
        end
        if (dk_sh >= divisor)
        begin
            dk_rem_next = dk_sub[CNT_W-1:0];
            dk_dvd_next = {dk_dvd_reg[DIV_W-2:0], 1'b1};
        end
        else
        begin
            dk_rem_next = dk_sh[CNT_W-1:0];
            dk_dvd_next = {dk_dvd_reg[DIV_W-2:0], 1'b0};
        end
    end

    assign status.div_last = (step_reg == '0);

    assign raw_scaled = TENTHS_N_W'(sample_reg) * TENTHS_N_W'(TENTHS_SPAN);
    assign avg_dark   = tenths_of(dk_dvd_reg[TENTHS_N_W-1:0]);
    assign used_ext   = {{USED_W{1'b0}}, fill_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            slot_reg <= '0;
            fill_reg <= '0;
        end
        else if (cmd.update)
        begin
            sum_reg  <= sum_next;
            slot_reg <= slot_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
        if (cmd.scale)
        begin
            q4_dvd_reg   <= DIV_W'({sum_reg, 4'b0000});
            dk_dvd_reg   <= DIV_W'(sum_reg) * DIV_W'(TENTHS_SPAN);
            q4_rem_reg   <= '0;
            dk_rem_reg   <= '0;
            step_reg     <= STEP_W'(DIV_W - 1);
            raw_dark_reg <= tenths_of(raw_scaled);
        end
        if (cmd.step)
        begin
            q4_dvd_reg <= q4_dvd_next;
            q4_rem_reg <= q4_rem_next;
            dk_dvd_reg <= dk_dvd_next;
            dk_rem_reg <= dk_rem_next;
            step_reg   <= step_reg - STEP_W'(1);
        end
        if (cmd.finish)
        begin
            raw_echo_reg          <= sample_reg;
            average_q4_reg        <= q4_dvd_reg[AVG_W-1:0];
            raw_dark_tenths_reg   <= raw_dark_reg;
            raw_bright_tenths_reg <= TENTHS_W'(TENTHS_SPAN) - raw_dark_reg;
            avg_dark_tenths_reg   <= avg_dark;
            avg_bright_tenths_reg <= TENTHS_W'(TENTHS_SPAN) - avg_dark;
            samples_used_reg      <= used_ext[USED_W-1:0];
        end
    end

    assign m_tdata = {
        {(M_TDATA_W - 68){1'b0}},
        samples_used_reg,
        avg_bright_tenths_reg,
        avg_dark_tenths_reg,
        raw_bright_tenths_reg,
        raw_dark_tenths_reg,
        average_q4_reg,
        raw_echo_reg
    };

endmodule

[src/moving_average_light_level_core.sv]
// Channel  Dir  Width  Contents
// s_*      in   16     sample [9:0]
// m_*      out  72     raw_echo, average_q4, raw_dark_tenths, raw_bright_tenths,
//                      avg_dark_tenths, avg_bright_tenths, samples_used
//
// An item passes through update, scale, one divide step per bit of DIV_W and finish
// before the next acceptance, where DIV_W is the bit count of WINDOW*1023*1000 (24 at
// WINDOW = 10); s_tready stays low until finish is done, so no new sample is taken
// while one is in progress. The two-lane serial divider by the fill count sets that pace.
// Reset clears the running sum, the write slot and the fill count; the ring is
// not swept, since slots past the fill count read as zero.
// A held result stalls only the finish state of the next item.
module moving_average_light_level_core #(
    parameter int WINDOW = mall_pkg::WINDOW_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mall_pkg::S_TDATA_W-1:0] s_tdata,  // sample[9:0], zero pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // raw_echo[9:0], average_q4[23:10], raw_dark_tenths[33:24],
    // raw_bright_tenths[43:34], avg_dark_tenths[53:44],
    // avg_bright_tenths[63:54], samples_used[67:64], zero pad
    output logic [mall_pkg::M_TDATA_W-1:0] m_tdata
);

    import mall_pkg::*;

    mall_cmd_t    cmd;
    mall_status_t status;

    mall_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mall_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .status  (status)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in progress");

    a_divide_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && status.div_last) |=> !cmd.step)
        else $error("division ran past its last step");

    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.finish))
        else $error("output valid without a stored result");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

endmodule
